[rtl/priority_command_mux_with_timeout_top_macros.svh]
// assertion macros shared by the rtl
// each use samples on the rising edge of clk and is off while arst_n is low
`ifndef PRIORITY_COMMAND_MUX_WITH_TIMEOUT_TOP_MACROS_SVH
`define PRIORITY_COMMAND_MUX_WITH_TIMEOUT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PCMT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: check failed");
`define PCMT_ASSERT_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
`else
`define PCMT_ASSERT(label, prop)
`define PCMT_ASSERT_MSG(label, prop, msg)
`endif

`endif

[rtl/pcmt_pkg.sv]
package pcmt_pkg;

	localparam int unsigned NCH = 2;
	localparam int unsigned NWORD = 6;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned CMD_W = NWORD * WORD_W;
	localparam int unsigned AGE_W = 17;
	localparam int unsigned PRI_W = 8;
	localparam int unsigned TMO_W = 16;
	localparam int unsigned PER_W = 10;
	localparam int unsigned SRC_W = 2;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(65536);

	// input word kinds
	localparam logic MODE_ARRIVAL = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// result sources
	localparam logic [SRC_W-1:0] SRC_CH0 = 2'd0;
	localparam logic [SRC_W-1:0] SRC_CH1 = 2'd1;
	localparam logic [SRC_W-1:0] SRC_STOP = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRIORITY_A = 3'd0,
		REG_PRIORITY_B = 3'd1,
		REG_TIMEOUT_A = 3'd2,
		REG_TIMEOUT_B = 3'd3,
		REG_STOP_IDLE = 3'd4,
		REG_PUBLISH_PERIOD = 3'd5
	} cfg_reg_t;

	localparam logic [PRI_W-1:0] RST_PRIORITY_A = 8'd100;
	localparam logic [PRI_W-1:0] RST_PRIORITY_B = 8'd50;
	localparam logic [TMO_W-1:0] RST_TIMEOUT_A = 16'd200;
	localparam logic [TMO_W-1:0] RST_TIMEOUT_B = 16'd300;
	localparam logic RST_STOP_IDLE = 1'b1;
	localparam logic [PER_W-1:0] RST_PUBLISH_PERIOD = 10'd20;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [AGE_W-1:0] age_t;

	// arbitration outcome for one tick
	typedef struct packed {
		logic emit;
		logic [SRC_W-1:0] source;
	} pick_t;

	// channel settings handed to the arbiter
	typedef struct packed {
		logic [PRI_W-1:0] pri_a;
		logic [PRI_W-1:0] pri_b;
		logic [TMO_W-1:0] tmo_a;
		logic [TMO_W-1:0] tmo_b;
		logic stop_idle;
	} arb_cfg_t;

endpackage

[rtl/priority_command_mux_with_timeout_top.sv]
// an input word is registered, then processed; a result word is loaded into the
// output register when a tick word that ends a publish period and has something to send is processed
// throughput: one input word per cycle, set by the single input stage that
// processes a word per cycle while the output register is free or being drained
// reset: arst_n clears control state and loads the register defaults at once
`include "priority_command_mux_with_timeout_top_macros.svh"

module priority_command_mux_with_timeout_top (
	input logic clk,
	input logic arst_n,
	// configuration writes
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [pcmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pcmt_pkg::CFG_DATA_W-1:0] cfg_data,
	// input words
	input logic s_tvalid,
	output logic s_tready,
	input logic [pcmt_pkg::CMD_W-1:0] s_tdata, // lin_x, lin_y, lin_z, ang_x, ang_y, ang_z
	input logic [1:0] s_tuser, // mode, channel
	// result words
	output logic m_tvalid,
	input logic m_tready,
	output logic [pcmt_pkg::CMD_W-1:0] m_tdata, // out_lin_x .. out_ang_z, lin_x lowest
	output logic [pcmt_pkg::SRC_W-1:0] m_tuser // source
);

	// configuration registers
	logic [pcmt_pkg::PRI_W-1:0] pri_a_q;
	logic [pcmt_pkg::PRI_W-1:0] pri_b_q;
	logic [pcmt_pkg::TMO_W-1:0] tmo_a_q;
	logic [pcmt_pkg::TMO_W-1:0] tmo_b_q;
	logic stop_idle_q;
	logic [pcmt_pkg::PER_W-1:0] period_q;

	// input stage
	logic valid_s1;
	logic mode_s1;
	logic chan_s1;
	pcmt_pkg::cmd_t cmd_s1;

	// channel state; held commands are never read before their channel is received
	pcmt_pkg::cmd_t held_q [pcmt_pkg::NCH];
	logic [pcmt_pkg::NCH-1:0] recv_q;
	pcmt_pkg::age_t age_q [pcmt_pkg::NCH];
	pcmt_pkg::age_t age_nxt [pcmt_pkg::NCH];
	logic [pcmt_pkg::PER_W-1:0] count_q;

	// result register
	logic m_valid_q;
	logic [pcmt_pkg::SRC_W-1:0] src_q;
	pcmt_pkg::cmd_t data_q;

	logic advance;
	logic is_tick;
	logic [pcmt_pkg::PER_W-1:0] period_eff;
	logic [pcmt_pkg::PER_W:0] count_inc;
	logic period_end;
	pcmt_pkg::arb_cfg_t arb_cfg;
	pcmt_pkg::pick_t pick;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pri_a_q <= pcmt_pkg::RST_PRIORITY_A;
			pri_b_q <= pcmt_pkg::RST_PRIORITY_B;
			tmo_a_q <= pcmt_pkg::RST_TIMEOUT_A;
			tmo_b_q <= pcmt_pkg::RST_TIMEOUT_B;
			stop_idle_q <= pcmt_pkg::RST_STOP_IDLE;
			period_q <= pcmt_pkg::RST_PUBLISH_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pcmt_pkg::cfg_reg_t'(cfg_index))
				pcmt_pkg::REG_PRIORITY_A: pri_a_q <= cfg_data[pcmt_pkg::PRI_W-1:0];
				pcmt_pkg::REG_PRIORITY_B: pri_b_q <= cfg_data[pcmt_pkg::PRI_W-1:0];
				pcmt_pkg::REG_TIMEOUT_A: tmo_a_q <= cfg_data[pcmt_pkg::TMO_W-1:0];
				pcmt_pkg::REG_TIMEOUT_B: tmo_b_q <= cfg_data[pcmt_pkg::TMO_W-1:0];
				pcmt_pkg::REG_STOP_IDLE: stop_idle_q <= cfg_data[0];
				pcmt_pkg::REG_PUBLISH_PERIOD: period_q <= cfg_data[pcmt_pkg::PER_W-1:0];
				default: ;  // indexes past the list are dropped
			endcase
		end
	end

	// the input stage moves on whenever the result register is free or draining
	assign advance = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= s_tuser[0];
			chan_s1 <= s_tuser[1];
			cmd_s1 <= s_tdata;
		end
	end

	assign is_tick = (mode_s1 == pcmt_pkg::MODE_TICK);

	// a zero period behaves as one; >= catches a period lowered below the count
	assign period_eff = (period_q == '0) ? pcmt_pkg::PER_W'(1) : period_q;
	assign count_inc = {1'b0, count_q} + (pcmt_pkg::PER_W + 1)'(1);
	assign period_end = (count_inc >= {1'b0, period_eff});

	assign arb_cfg = '{
		pri_a: pri_a_q,
		pri_b: pri_b_q,
		tmo_a: tmo_a_q,
		tmo_b: tmo_b_q,
		stop_idle: stop_idle_q
	};

	pcmt_arb u_arb (
		.cfg(arb_cfg),
		.recv(recv_q),
		.age(age_q),
		.age_nxt(age_nxt),
		.pick(pick)
	);

	// held commands: written on arrival, no reset
	always_ff @(posedge clk) begin
		if (advance && !is_tick) begin
			held_q[chan_s1] <= cmd_s1;
		end
	end

	// received flags, ages and the publish counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_q <= '0;
			for (int c = 0; c < int'(pcmt_pkg::NCH); c++) begin
				age_q[c] <= '0;
			end
			count_q <= '0;
		end else if (advance) begin
			if (is_tick) begin
				for (int c = 0; c < int'(pcmt_pkg::NCH); c++) begin
					age_q[c] <= age_nxt[c];
				end
				count_q <= period_end ? '0 : count_inc[pcmt_pkg::PER_W-1:0];
			end else begin
				recv_q[chan_s1] <= 1'b1;
				age_q[chan_s1] <= '0;
			end
		end
	end

	// result register: loaded on a tick that ends a period and has something to send
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && is_tick && period_end && pick.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_tick && period_end && pick.emit) begin
			src_q <= pick.source;
			data_q <= (pick.source == pcmt_pkg::SRC_STOP) ? '0 : held_q[pick.source[0]];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = data_q;
	assign m_tuser = src_q;

	// a new result word only follows a processed tick
	`PCMT_ASSERT_MSG(a_result_after_tick, $rose(m_valid_q) |-> $past(advance && is_tick), "result without tick")
	// stop words carry an all-zero command
	`PCMT_ASSERT(a_stop_zero, (m_valid_q && src_q == pcmt_pkg::SRC_STOP) |-> (data_q == '0))
	// a channel is only selected once it has received a command
	`PCMT_ASSERT(a_sel_received, (m_valid_q && src_q != pcmt_pkg::SRC_STOP) |-> recv_q[src_q[0]])
	// ages saturate
	`PCMT_ASSERT(a_age_sat, (age_q[0] <= pcmt_pkg::AGE_MAX) && (age_q[1] <= pcmt_pkg::AGE_MAX))

endmodule

[rtl/pcmt_arb.sv]
// ages each channel a tick; picks top-priority live one, else stop if stop_idle
module pcmt_arb (
	input pcmt_pkg::arb_cfg_t cfg,
	input logic [pcmt_pkg::NCH-1:0] recv,
	input pcmt_pkg::age_t age [pcmt_pkg::NCH],
	output pcmt_pkg::age_t age_nxt [pcmt_pkg::NCH],
	output pcmt_pkg::pick_t pick
);

	logic alive0;
	logic alive1;
	logic take0;

	// saturating increment
	always_comb begin
		for (int c = 0; c < int'(pcmt_pkg::NCH); c++) begin
			age_nxt[c] = (age[c] == pcmt_pkg::AGE_MAX) ? age[c] : age[c] + pcmt_pkg::AGE_W'(1);
		end
	end

	assign alive0 = recv[0] && (age_nxt[0] <= {1'b0, cfg.tmo_a});
	assign alive1 = recv[1] && (age_nxt[1] <= {1'b0, cfg.tmo_b});

	// channel 0 keeps a tie
	assign take0 = alive0 && (!alive1 || (cfg.pri_a >= cfg.pri_b));

	always_comb begin
		priority if (take0) begin
			pick.emit = 1'b1;
			pick.source = pcmt_pkg::SRC_CH0;
		end else if (alive1) begin
			pick.emit = 1'b1;
			pick.source = pcmt_pkg::SRC_CH1;
		end else begin
			pick.emit = cfg.stop_idle;
			pick.source = pcmt_pkg::SRC_STOP;
		end
	end

endmodule
